>>> hdl/bst_pkg.sv
package bst_pkg;

    localparam int ENTRY_BITS    = 32;
    localparam int INDEX_BITS    = 10;
    localparam int COUNT_BITS    = 11;
    localparam int POS_BITS      = 10;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // register index, taken from the word address paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic                         func;
        logic [INDEX_BITS-1:0]        entry_index;
        logic signed [ENTRY_BITS-1:0] entry_value;
        logic signed [ENTRY_BITS-1:0] search_key;
    } cmd_t;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
    } rsp_t;

endpackage

>>> hdl/bst_mem.sv
module bst_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bst_seq.sv
module bst_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  bst_pkg::cmd_t                        cmd,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output bst_pkg::rsp_t                        rsp,
    input  logic [bst_pkg::COUNT_BITS-1:0]       count,
    output logic                                 we,
    output logic [$clog2(TABLE_DEPTH)-1:0]       waddr,
    output logic [VALUE_BITS-1:0]                wdata,
    output logic                                 re,
    output logic [$clog2(TABLE_DEPTH)-1:0]       raddr,
    input  logic [VALUE_BITS-1:0]                rdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PW    = IDX_W + 1;
    localparam int CW    = (PW > bst_pkg::COUNT_BITS) ? PW : bst_pkg::COUNT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_HOLD
    } state_t;

    state_t                  state_reg,     state_next;
    logic [PW-1:0]           left_reg,      left_next;
    logic [PW-1:0]           hi_reg,        hi_next;   // exclusive upper bound
    logic [IDX_W-1:0]        mid_reg,       mid_next;
    logic signed [VALUE_BITS-1:0] key_reg,  key_next;
    bst_pkg::rsp_t           hold_reg,      hold_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    bst_pkg::rsp_t           rsp_reg,       rsp_next;

    logic [PW-1:0]           n_sat;
    logic [IDX_W-1:0]        mid_start;
    logic [PW-1:0]           mid_ext;
    logic [PW-1:0]           lo_up;
    logic [PW-1:0]           mid_a_ext;
    logic [PW-1:0]           mid_b_ext;
    logic                    go_a;
    logic                    go_b;
    logic signed [VALUE_BITS-1:0] entry;
    logic                    eq;
    logic                    lt;
    logic                    out_free;
    logic                    finish;
    bst_pkg::rsp_t           fin_rsp;
    logic                    accept;

    assign accept   = cmd_valid && !cmd_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // clamp the configured count to the table depth
    always_comb
    begin
        if (CW'(count) > CW'(TABLE_DEPTH))
        begin
            n_sat = PW'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = PW'(count);
        end
    end

    assign mid_start = IDX_W'((n_sat - PW'(1)) >> 1);

    // both candidate next probes are formed in parallel with the compare
    assign entry     = $signed(rdata);
    assign eq        = (entry == key_reg);
    assign lt        = (entry < key_reg);
    assign mid_ext   = PW'(mid_reg);
    assign lo_up     = mid_ext + PW'(1);
    assign mid_a_ext = lo_up + ((hi_reg - lo_up - PW'(1)) >> 1);
    assign mid_b_ext = left_reg + ((mid_ext - left_reg - PW'(1)) >> 1);
    assign go_a      = (lo_up < hi_reg);
    assign go_b      = (left_reg < mid_ext);

    // write path: gives no result
    assign we = accept && (cmd.func == bst_pkg::FUNC_WRITE)
                && (CW'(cmd.entry_index) < CW'(TABLE_DEPTH));
    assign waddr = IDX_W'(cmd.entry_index);
    assign wdata = VALUE_BITS'(cmd.entry_value);

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        re             = 1'b0;
        raddr          = mid_reg;
        finish         = 1'b0;
        fin_rsp        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.func == bst_pkg::FUNC_SEARCH)
                begin
                    key_next  = VALUE_BITS'(cmd.search_key);
                    left_next = '0;
                    hi_next   = n_sat;
                    if (n_sat == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        mid_next   = mid_start;
                        re         = 1'b1;
                        raddr      = mid_start;
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (eq)
                begin
                    finish           = 1'b1;
                    fin_rsp.found    = 1'b1;
                    fin_rsp.position = bst_pkg::POS_BITS'(mid_reg);
                end
                else if (lt)
                begin
                    if (go_a)
                    begin
                        left_next = lo_up;
                        mid_next  = IDX_W'(mid_a_ext);
                        re        = 1'b1;
                        raddr     = IDX_W'(mid_a_ext);
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    if (go_b)
                    begin
                        hi_next  = mid_ext;
                        mid_next = IDX_W'(mid_b_ext);
                        re       = 1'b1;
                        raddr    = IDX_W'(mid_b_ext);
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_HOLD:
            begin
                finish  = 1'b1;
                fin_rsp = hold_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // push the result, or park it until the output register frees up
        if (finish)
        begin
            if (out_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = fin_rsp;
                state_next     = S_IDLE;
            end
            else
            begin
                hold_next  = fin_rsp;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            key_reg       <= '0;
            hold_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            key_reg       <= key_next;
            hold_reg      <= hold_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_read_leads_probe: assert property (@(posedge clk) disable iff (!rst_n)
        re |=> state_reg == S_PROBE)
        else $error("table read not followed by a probe cycle");

    a_mid_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> (mid_ext < hi_reg) && (left_reg <= mid_ext))
        else $error("probe index outside search bounds");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.found |-> rsp_reg.position == '0)
        else $error("not-found result carries nonzero position");

    a_hold_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HOLD |-> rsp_valid_reg)
        else $error("result parked while output register empty");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == S_IDLE && !re)
        else $error("table write during a search");
`endif

endmodule

>>> hdl/binary_search_table.sv
// Binary search over a table of signed entries.
// cmd channel (cmd_valid / cmd_stall / cmd): func selects a write of
// entry_value at entry_index, or a search for search_key. A transfer
// happens when cmd_valid is high and cmd_stall is low.
// rsp channel (rsp_valid / rsp_stall / rsp): one result per search,
// found and position; writes give no result.
// entry_count is set over the APB port at byte address 0. The user must
// set it only while idle; the block itself does not enforce this. A
// search reads the synchronous table, which has separate read and write
// ports, once per probe. cmd_stall is high while a search runs or its
// result is parked. A finished result sits in the rsp output register;
// a new command is taken while it waits, and a later search result
// parks until the receiver drops rsp_stall.
// Reset clears entry_count and the control state; table contents stay
// undefined until written.
module binary_search_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  bst_pkg::cmd_t                       cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output bst_pkg::rsp_t                       rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bst_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [bst_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [bst_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [bst_pkg::COUNT_BITS-1:0] count_reg;
    logic                           cfg_wr;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [VALUE_BITS-1:0]          mem_wdata;
    logic                           mem_re;
    logic [IDX_W-1:0]               mem_raddr;
    logic [VALUE_BITS-1:0]          mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr && paddr[2] == bst_pkg::REG_ENTRY_COUNT)
        begin
            count_reg <= pwdata[bst_pkg::COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == bst_pkg::REG_ENTRY_COUNT)
        begin
            prdata = bst_pkg::CFG_DATA_BITS'(count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    bst_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bst_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .count     (count_reg),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .re        (mem_re),
        .raddr     (mem_raddr),
        .rdata     (mem_rdata)
    );

endmodule

>>> tb/bst_checker.sv
`timescale 1ns / 1ps

module bst_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_stall,
    input  bst_pkg::cmd_t                       cmd,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  bst_pkg::rsp_t                       rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bst_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [bst_pkg::CFG_DATA_BITS-1:0]   pwdata,
    input  logic [bst_pkg::CFG_DATA_BITS-1:0]   prdata,
    input  logic                                pready,
    output int                                  errors,
    output int                                  outstanding
);

    localparam int MAX_REPORTS = 10;

    logic signed [bst_pkg::ENTRY_BITS-1:0] entry_mirror [TABLE_DEPTH];
    logic [bst_pkg::COUNT_BITS-1:0]        count_mirror;
    bst_pkg::rsp_t                         pending_answers [$];
    int                                    mismatches = 0;

    // Walk the probe sequence exactly as the block does; duplicates and
    // unsorted tables resolve to whatever index this order lands on first.
    function automatic bst_pkg::rsp_t probe_table(
        input logic signed [bst_pkg::ENTRY_BITS-1:0] key);
        int            lo;
        int            hi;
        int            mid;
        bst_pkg::rsp_t answer;
        answer = '0;
        lo = 0;
        hi = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(count_mirror) - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (entry_mirror[mid] == key)
            begin
                answer.found    = 1'b1;
                answer.position = bst_pkg::POS_BITS'(mid);
                return answer;
            end
            else if (entry_mirror[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return answer;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bst_pkg::rsp_t want;
        if (!rst_n)
        begin
            count_mirror = '0;
            pending_answers.delete();
            errors      <= mismatches;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == bst_pkg::REG_ENTRY_COUNT)
                        count_mirror = pwdata[bst_pkg::COUNT_BITS-1:0];
                end
                else if (paddr[2] == bst_pkg::REG_ENTRY_COUNT
                         && prdata !== bst_pkg::CFG_DATA_BITS'(count_mirror))
                    log_mismatch($sformatf("entry_count read back %0d, expected %0d",
                                           prdata, count_mirror));
            end

            if (cmd_valid && !cmd_stall)
            begin
                if (cmd.func == bst_pkg::FUNC_WRITE)
                    entry_mirror[cmd.entry_index] = cmd.entry_value;
                else
                    pending_answers.push_back(probe_table(cmd.search_key));
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (pending_answers.size() == 0)
                    log_mismatch($sformatf(
                        "search result with no search pending: found=%0d position=%0d",
                        rsp.found, rsp.position));
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.found !== want.found || rsp.position !== want.position)
                        log_mismatch($sformatf(
                            {"search result expected found=%0d position=%0d, ",
                             "got found=%0d position=%0d"},
                            want.found, want.position, rsp.found, rsp.position));
                end
            end

            errors      <= mismatches;
            outstanding <= pending_answers.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH = 1024;
    localparam int NUM_ITEMS   = 1300;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PCT    = 22;
    localparam int SMALL_TABLE = 64;

    localparam logic [bst_pkg::CFG_ADDR_BITS-1:0] ADDR_ENTRY_COUNT =
        {bst_pkg::REG_ENTRY_COUNT, 2'b00};
    localparam logic [bst_pkg::CFG_ADDR_BITS-1:0] ADDR_SPARE =
        {~bst_pkg::REG_ENTRY_COUNT, 2'b00};

    localparam logic signed [bst_pkg::ENTRY_BITS-1:0] VAL_MIN =
        {1'b1, {(bst_pkg::ENTRY_BITS-1){1'b0}}};
    localparam logic signed [bst_pkg::ENTRY_BITS-1:0] VAL_MAX =
        {1'b0, {(bst_pkg::ENTRY_BITS-1){1'b1}}};

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cmd_valid = 1'b0;
    logic                              cmd_stall;
    bst_pkg::cmd_t                     cmd       = '0;
    logic                              rsp_valid;
    logic                              rsp_stall = 1'b0;
    bst_pkg::rsp_t                     rsp;
    logic                              psel      = 1'b0;
    logic                              penable   = 1'b0;
    logic                              pwrite    = 1'b0;
    logic [bst_pkg::CFG_ADDR_BITS-1:0] paddr     = '0;
    logic [bst_pkg::CFG_DATA_BITS-1:0] pwdata    = '0;
    logic [bst_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                              pready;

    int  errors;
    int  outstanding;
    int  cycles     = 0;
    int  items_sent = 0;
    bit  calm       = 1'b0;

    // values last written per index, used to aim search keys at real entries
    logic signed [bst_pkg::ENTRY_BITS-1:0] stored_values [TABLE_DEPTH];

    binary_search_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (bst_pkg::ENTRY_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    bst_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bst_pkg::cmd_t make_write(
        input int idx, input logic [bst_pkg::ENTRY_BITS-1:0] val);
        bst_pkg::cmd_t c;
        c.func        = bst_pkg::FUNC_WRITE;
        c.entry_index = bst_pkg::INDEX_BITS'(idx);
        c.entry_value = val;
        c.search_key  = $urandom();
        return c;
    endfunction

    function automatic bst_pkg::cmd_t make_search(
        input logic signed [bst_pkg::ENTRY_BITS-1:0] key);
        bst_pkg::cmd_t c;
        c.func        = bst_pkg::FUNC_SEARCH;
        c.entry_index = bst_pkg::INDEX_BITS'($urandom());
        c.entry_value = $urandom();
        c.search_key  = key;
        return c;
    endfunction

    // Hold valid until the transfer; keep it high across back-to-back items.
    task automatic send_cmd(input bst_pkg::cmd_t c);
        calm <= (items_sent >= 300 && items_sent < 550);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    // Drain all searches, then give a trailing write time to land.
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic apb_write(input logic [bst_pkg::CFG_ADDR_BITS-1:0] addr,
                             input logic [bst_pkg::CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [bst_pkg::CFG_ADDR_BITS-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Upper data bits are junk on purpose; a write to the spare address must not land.
    task automatic set_count(input logic [bst_pkg::COUNT_BITS-1:0] n);
        logic [bst_pkg::CFG_DATA_BITS-1:0] data;
        data = $urandom();
        data[bst_pkg::COUNT_BITS-1:0] = n;
        apb_write(ADDR_ENTRY_COUNT, data);
        if ($urandom_range(0, 3) == 0)
            apb_write(ADDR_SPARE, $urandom());
        apb_read(ADDR_ENTRY_COUNT);
    endtask

    // Fill entries 0..n-1, ascending with runs of duplicates, or scrambled.
    task automatic load_table(input int n, input bit ordered);
        longint                          level;
        logic [bst_pkg::ENTRY_BITS-1:0]  val;
        if ($urandom_range(0, 3) == 0)
            level = longint'(VAL_MIN);
        else
            level = longint'($signed($urandom())) >>> 1;
        for (int i = 0; i < n; i++)
        begin
            if (ordered)
            begin
                if (i > 0)
                    case ($urandom_range(0, 3))
                        0: ;
                        1: level += $urandom_range(1, 3);
                        2: level += $urandom_range(1, 1000);
                        default: level += $urandom_range(1, 1 << 22);
                    endcase
                if (level > longint'(VAL_MAX))
                    level = longint'(VAL_MAX);
                val = level[bst_pkg::ENTRY_BITS-1:0];
            end
            else
                val = $urandom();
            send_cmd(make_write(i, val));
            stored_values[i] = val;
        end
    endtask

    initial
    begin
        int                                    n_eff;
        int                                    idx;
        bit                                    first;
        logic [bst_pkg::COUNT_BITS-1:0]        count;
        logic [bst_pkg::ENTRY_BITS-1:0]        val;
        logic signed [bst_pkg::ENTRY_BITS-1:0] key;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        set_count('0);
        send_cmd(make_search('0));
        send_cmd(make_search(VAL_MIN));

        // five entries spanning the signed range, plus the top index
        wait_idle();
        set_count(bst_pkg::COUNT_BITS'(5));
        send_cmd(make_write(0, VAL_MIN));
        send_cmd(make_write(1, -1));
        send_cmd(make_write(2, 0));
        send_cmd(make_write(3, 1));
        send_cmd(make_write(4, VAL_MAX));
        send_cmd(make_write(TABLE_DEPTH - 1, 32'h5A5A_A5A5));
        send_cmd(make_search(VAL_MIN));
        send_cmd(make_search(-1));
        send_cmd(make_search(0));
        send_cmd(make_search(1));
        send_cmd(make_search(VAL_MAX));
        send_cmd(make_search(2));
        send_cmd(make_search(VAL_MIN + 1));
        send_cmd(make_search(VAL_MAX - 1));

        // duplicates, then an out-of-order entry
        send_cmd(make_write(1, 0));
        send_cmd(make_write(3, 0));
        send_cmd(make_search(0));
        send_cmd(make_write(2, 7));
        send_cmd(make_search(7));
        send_cmd(make_search(0));

        // fill the whole table once so any count is safe to search
        wait_idle();
        set_count(bst_pkg::COUNT_BITS'(TABLE_DEPTH));
        load_table(TABLE_DEPTH, 1'b1);
        items_sent = 0;
        n_eff = TABLE_DEPTH;
        first = 1'b1;

        while (items_sent < NUM_ITEMS)
        begin
            if (!first)
            begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0: count = '0;
                    1:
                        case ($urandom_range(0, 5))
                            0: count = bst_pkg::COUNT_BITS'(1);
                            1: count = bst_pkg::COUNT_BITS'(2);
                            2: count = bst_pkg::COUNT_BITS'(TABLE_DEPTH - 1);
                            3: count = bst_pkg::COUNT_BITS'(TABLE_DEPTH);
                            4: count = bst_pkg::COUNT_BITS'(TABLE_DEPTH + 1);
                            default: count = '1;
                        endcase
                    2: count = bst_pkg::COUNT_BITS'($urandom_range(
                           TABLE_DEPTH + 1, (1 << bst_pkg::COUNT_BITS) - 1));
                    default: count = bst_pkg::COUNT_BITS'($urandom_range(1, SMALL_TABLE));
                endcase
                set_count(count);
                n_eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
                if (n_eff <= SMALL_TABLE)
                    load_table(n_eff, $urandom_range(0, 5) != 0);
            end
            first = 1'b0;

            repeat ($urandom_range(10, 60))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    idx = $urandom_range(0, TABLE_DEPTH - 1);
                    val = $urandom();
                    send_cmd(make_write(idx, val));
                    stored_values[idx] = val;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4:
                            key = (n_eff > 0)
                                ? stored_values[$urandom_range(0, n_eff - 1)]
                                : bst_pkg::ENTRY_BITS'($urandom());
                        5, 6:
                        begin
                            key = (n_eff > 0)
                                ? stored_values[$urandom_range(0, n_eff - 1)] : '0;
                            key = $urandom_range(0, 1) ? key + 1 : key - 1;
                        end
                        7:
                            case ($urandom_range(0, 3))
                                0: key = VAL_MIN;
                                1: key = VAL_MAX;
                                2: key = '0;
                                default: key = '1;
                            endcase
                        default: key = $urandom();
                    endcase
                    send_cmd(make_search(key));
                end
            end
        end

        wait_idle();
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/bst_pkg.sv
hdl/bst_mem.sv
hdl/bst_seq.sv
hdl/binary_search_table.sv
tb/bst_checker.sv
tb/tb_top.sv
